// ----- hw/rtl/rdq_pkg.sv -----
// Shared types and codes for the reversible deque core.
package rdq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned DEPTH_DEF = 1024;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STATUS_W-1:0]      status_t;

  localparam cmd_t CMD_POP_BACK   = 3'd0;
  localparam cmd_t CMD_POP_FRONT  = 3'd1;
  localparam cmd_t CMD_TOGGLE     = 3'd2;
  localparam cmd_t CMD_PUSH_BACK  = 3'd3;
  localparam cmd_t CMD_PUSH_FRONT = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // write request into the entry cell of the ring
  typedef struct packed {
    logic  load;
    data_t data;
  } ring_wr_t;

endpackage

// ----- hw/rtl/rdq_if.sv -----
// Valid/ready channel interfaces for command and result words.
interface rdq_in_if;
  import rdq_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  data_t push_value;
  modport source (output valid, output cmd, output push_value, input ready);
  modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface rdq_out_if;
  import rdq_pkg::*;
  logic    valid;
  logic    ready;
  data_t   pop_value;
  status_t status;
  modport source (output valid, output pop_value, output status, input ready);
  modport sink (input valid, input pop_value, input status, output ready);
endinterface

// ----- hw/rtl/rdq_cell.sv -----
// One storage cell of the recirculating ring: takes its neighbour's entry or a new one.
module rdq_cell (
  input  logic          clk,
  input  logic          load,
  input  rdq_pkg::data_t load_data,
  input  rdq_pkg::data_t shift_in,
  output rdq_pkg::data_t q
);
  import rdq_pkg::*;

  data_t q_r;

  always_ff @(posedge clk) begin
    q_r <= load ? load_data : shift_in;
  end

  assign q = q_r;

endmodule

// ----- hw/rtl/rdq_ring.sv -----
// Ring of entry cells rotating one place per cycle; writes enter at cell 0, reads at the tap.
module rdq_ring #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  rdq_pkg::ring_wr_t ring_wr,
  output rdq_pkg::data_t    tap_data
);
  import rdq_pkg::*;

  data_t cell_q [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_entry
      // closes the ring: the tap's entry re-enters here unless overwritten
      rdq_cell u_cell (
        .clk       (clk),
        .load      (ring_wr.load),
        .load_data (ring_wr.data),
        .shift_in  (cell_q[DEPTH-1]),
        .q         (cell_q[g])
      );
    end else begin : g_body
      rdq_cell u_cell (
        .clk       (clk),
        .load      (1'b0),
        .load_data (ring_wr.data),
        .shift_in  (cell_q[g-1]),
        .q         (cell_q[g])
      );
    end
  end

  assign tap_data = cell_q[DEPTH-1];

endmodule

// ----- hw/rtl/rdq_ctrl.sv -----
// Deque controller: end pointers, reverse flag, slot tracking and result register.
module rdq_ctrl #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rdq_in_if.sink            in_ch,
  rdq_out_if.source         out_ch,
  input  rdq_pkg::data_t    tap_data,
  output rdq_pkg::ring_wr_t ring_wr
);
  import rdq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEEK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;      // physical slot now at the ring tap
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rev_r, rev_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic          seek_wr_r, seek_wr_nxt;
  data_t         hold_val_r, hold_val_nxt;
  status_t       hold_st_r, hold_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  data_t         out_val_r;
  status_t       out_st_r;

  logic          accept;
  logic          at_front;
  logic          empty;
  logic          full;
  logic          match;
  logic          out_free;
  logic          out_load;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] head_dec;
  logic [CW:0]   sum_w;
  logic [CW:0]   sum_m1;
  logic [CW:0]   back_w;
  logic [CW:0]   last_w;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign at_front    = ((in_ch.cmd == CMD_POP_FRONT) || (in_ch.cmd == CMD_PUSH_FRONT)) ^ rev_r;
  assign empty       = (cnt_r == '0);
  assign full        = (cnt_r == FULL_CNT);
  assign match       = (idx_r == tgt_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == S_EMIT) && out_free;

  assign idx_nxt  = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;

  // slot one past the back and slot of the back, each below twice the depth
  assign sum_w  = {{(CW + 1 - IW){1'b0}}, head_r} + {1'b0, cnt_r};
  assign sum_m1 = sum_w - 1'b1;
  assign back_w = (sum_w >= DEPTH_W) ? sum_w - DEPTH_W : sum_w;
  assign last_w = (sum_m1 >= DEPTH_W) ? sum_m1 - DEPTH_W : sum_m1;

  assign ring_wr.load = (state_r == S_SEEK) && seek_wr_r && match;
  assign ring_wr.data = hold_val_r;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    rev_nxt      = rev_r;
    tgt_nxt      = tgt_r;
    seek_wr_nxt  = seek_wr_r;
    hold_val_nxt = hold_val_r;
    hold_st_nxt  = hold_st_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            CMD_POP_BACK, CMD_POP_FRONT: begin
              if (empty) begin
                hold_val_nxt = '0;
                hold_st_nxt  = ST_EMPTY;
                state_nxt    = S_EMIT;
              end else begin
                tgt_nxt     = at_front ? head_r : last_w[IW-1:0];
                head_nxt    = at_front ? head_inc : head_r;
                cnt_nxt     = cnt_r - 1'b1;
                seek_wr_nxt = 1'b0;
                state_nxt   = S_SEEK;
              end
            end
            CMD_TOGGLE: begin
              rev_nxt = !rev_r;
            end
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              if (full) begin
                hold_val_nxt = '0;
                hold_st_nxt  = ST_FULL;
                state_nxt    = S_EMIT;
              end else begin
                tgt_nxt      = at_front ? head_dec : back_w[IW-1:0];
                head_nxt     = at_front ? head_dec : head_r;
                cnt_nxt      = cnt_r + 1'b1;
                seek_wr_nxt  = 1'b1;
                hold_val_nxt = in_ch.push_value;
                state_nxt    = S_SEEK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEEK: begin
        // wait for the addressed slot to come round to the tap
        if (match) begin
          if (seek_wr_r) begin
            state_nxt = S_IDLE;
          end else begin
            hold_val_nxt = tap_data;
            hold_st_nxt  = ST_OK;
            state_nxt    = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      seek_wr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      seek_wr_r   <= seek_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    hold_val_r <= hold_val_nxt;
    hold_st_r  <= hold_st_nxt;
    if (out_load) begin
      out_val_r <= hold_val_r;
      out_st_r  <= hold_st_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = out_val_r;
  assign out_ch.status    = out_st_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_IDX)
    else $error("head index out of range");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_ch.cmd == CMD_POP_BACK) || (in_ch.cmd == CMD_POP_FRONT)) && !empty)
    |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pop did not remove one entry");

  a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.cmd == CMD_TOGGLE)) |=> (rev_r != $past(rev_r)))
    else $error("reverse flag not flipped");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_OK)) |-> (out_val_r == '0))
    else $error("failed command carries a value");

endmodule

// ----- hw/rtl/reversible_deque_core.sv -----
// Reversible deque: entries recirculate through a ring of cells, one place per cycle.
// One command at a time. Toggle or unknown code: the input stays ready for the next command.
// Empty/full status: the result goes to the output register, then the next command. Push:
// wait for the target slot to reach the tap, write it, then the next command. Pop: wait
// likewise, take the entry from the tap, then the result; a second result waits for the output.
// Reset clears pointers, count, reverse flag and handshakes; entries stay undefined.
module reversible_deque_core #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rdq_in_if.sink    in_ch,
  rdq_out_if.source out_ch
);
  import rdq_pkg::*;

  ring_wr_t ring_wr;
  data_t    tap_data;

  rdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .tap_data (tap_data),
    .ring_wr  (ring_wr)
  );

  rdq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk      (clk),
    .ring_wr  (ring_wr),
    .tap_data (tap_data)
  );

endmodule

// ----- bench/tb_reversible_deque_core.sv -----
// Self-checking testbench for reversible_deque_core: directed, random and back-pressure words.
module tb_reversible_deque_core;
  import rdq_pkg::*;

  localparam int unsigned RING_DEPTH  = DEPTH_DEF;
  localparam int unsigned IDX_W       = $clog2(RING_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  // codes the block has no use for; it must swallow them silently
  localparam cmd_t CMD_SPARE_FIRST = 3'd5;
  localparam cmd_t CMD_SPARE_LAST  = 3'd7;

  localparam data_t VAL_MIN = 32'h8000_0000;
  localparam data_t VAL_MAX = 32'h7FFF_FFFF;

  typedef struct {
    data_t   value;
    status_t status;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rdq_in_if  cmd_ch ();
  rdq_out_if res_ch ();

  reversible_deque_core #(.DEPTH(RING_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deque state as the block should hold it
  data_t             ring_store [RING_DEPTH];
  bit [IDX_W-1:0]    front_idx;
  bit [IDX_W:0]      held_count;
  bit                reversed;

  deque_result_t     pending_results [$];
  int                mismatches;
  int unsigned       cycle_count;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_len;
  int                hold_seq;

  function automatic void expect_result(data_t val, status_t st);
    deque_result_t r;
    r.value  = val;
    r.status = st;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void apply_command(cmd_t op, data_t val);
    bit             at_front;
    bit [IDX_W-1:0] slot;
    data_t          popped;
    case (op)
      CMD_POP_BACK, CMD_POP_FRONT: begin
        at_front = (op == CMD_POP_FRONT) ^ reversed;
        if (held_count == 0) begin
          expect_result('0, ST_EMPTY);
        end else begin
          if (at_front) begin
            popped    = ring_store[front_idx];
            front_idx = IDX_W'((int'(front_idx) + 1) % RING_DEPTH);
          end else begin
            slot   = IDX_W'((int'(front_idx) + int'(held_count) - 1) % RING_DEPTH);
            popped = ring_store[slot];
          end
          held_count--;
          expect_result(popped, ST_OK);
        end
      end
      CMD_TOGGLE: reversed = !reversed;
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        at_front = (op == CMD_PUSH_FRONT) ^ reversed;
        if (held_count >= RING_DEPTH) begin
          expect_result('0, ST_FULL);
        end else begin
          if (at_front) begin
            front_idx             = IDX_W'((int'(front_idx) + RING_DEPTH - 1) % RING_DEPTH);
            ring_store[front_idx] = val;
          end else begin
            slot             = IDX_W'((int'(front_idx) + int'(held_count)) % RING_DEPTH);
            ring_store[slot] = val;
          end
          held_count++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(15))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic cmd_t pick_push();
    return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
  endfunction

  function automatic cmd_t pick_pop();
    return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  function automatic cmd_t pick_op(int pop_pct, int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < pop_pct) return pick_pop();
    if (roll < pop_pct + push_pct) return pick_push();
    if (roll < pop_pct + push_pct + 10) return CMD_TOGGLE;
    return cmd_t'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
  endfunction

  // drive one word from the falling edge, hold until taken
  task automatic send_word(input cmd_t op, input data_t val);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= op;
    cmd_ch.push_value <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    apply_command(op, val);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_pops();
    send_word(CMD_POP_BACK, pick_value());
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_TOGGLE, pick_value());
    send_word(CMD_POP_BACK, pick_value());
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_TOGGLE, pick_value());
    wait_all_results();
  endtask

  // extremes at both ends, front index wraps below zero, spare codes with words held
  task automatic test_ends_and_extremes();
    send_word(CMD_PUSH_BACK, VAL_MIN);
    send_word(CMD_PUSH_BACK, VAL_MAX);
    send_word(CMD_PUSH_FRONT, '0);
    send_word(CMD_PUSH_FRONT, '1);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      send_word(cmd_t'(c), pick_value());
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_POP_BACK, pick_value());
    send_word(CMD_TOGGLE, pick_value());
    send_word(CMD_POP_BACK, pick_value());
    send_word(CMD_PUSH_FRONT, 32'h5A5A_A5A5);
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_TOGGLE, pick_value());
    wait_all_results();
  endtask

  task automatic test_random_mix(int words, int send_pct, int recv_pct, int pop_pct,
                                 int push_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (words) send_word(pick_op(pop_pct, push_pct), pick_value());
    wait_all_results();
  endtask

  // result sink held off long enough for the output register and the pipe to back up
  task automatic test_long_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) send_word(pick_push(), pick_value());
    hold_len = 4000;
    hold_seq++;
    repeat (8) send_word(pick_pop(), pick_value());
    wait_all_results();
  endtask

  task automatic test_fill_to_full();
    send_idle_pct  = 0;
    recv_stall_pct = 9;
    while (held_count < RING_DEPTH)
      send_word($urandom_range(9) == 0 ? CMD_TOGGLE : pick_push(), pick_value());
    repeat (6) send_word(pick_push(), pick_value());
    send_word(CMD_TOGGLE, pick_value());
    send_word(CMD_PUSH_FRONT, pick_value());
    send_word(CMD_PUSH_BACK, pick_value());
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_POP_BACK, pick_value());
    send_word(CMD_PUSH_BACK, pick_value());
    send_word(CMD_PUSH_FRONT, pick_value());
    send_word(CMD_PUSH_FRONT, pick_value());
    wait_all_results();
  endtask

  // result sink: random stalls plus an occasional long hold-off
  initial begin : result_sink
    int hold_left;
    int seen_seq;
    hold_left    = 0;
    seen_seq     = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got value %0d status %0d",
                 $time, res_ch.pop_value, res_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.pop_value !== want.value) begin
          mismatches++;
          $display("%0t: pop_value expected %0d, got %0d",
                   $time, want.value, res_ch.pop_value);
        end
        if (res_ch.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, res_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.cmd        = CMD_POP_BACK;
    cmd_ch.push_value = '0;
    front_idx         = '0;
    held_count        = '0;
    reversed          = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_len          = 0;
    hold_seq          = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_ends_and_extremes();
    test_random_mix(100, 0, 0, 35, 45);
    test_random_mix(100, 83, 0, 35, 45);
    test_random_mix(100, 0, 83, 35, 45);
    test_random_mix(100, 9, 9, 35, 45);
    test_long_hold();
    test_fill_to_full();
    test_random_mix(60, 9, 9, 70, 20);

    // pushes give no word back, so let the last one finish
    repeat (RING_DEPTH + 8) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
